[hw/rtl/second_chance_page_replacer_defines.svh]
// Assertion macros shared by the checker files of the page replacer.
// No dependencies; every macro expects signals named clk and rst_n in scope.
`ifndef SECOND_CHANCE_PAGE_REPLACER_DEFINES_SVH
`define SECOND_CHANCE_PAGE_REPLACER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SCPR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scpr check failed");

// Next-cycle implication, checked outside reset.
`define SCPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scpr check failed");

`endif

[hw/rtl/scpr_pkg.sv]
// Shared constants for the second-chance page replacer.
// No dependencies; used by the top level, the RAM user and the checker.
package scpr_pkg;

  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 20;
  localparam int FRAME_W   = $clog2(FRAMES);
  localparam int CNT_W     = $clog2(FRAMES + 1);

  // Fixed port widths
  localparam int PAGE_W    = 20;
  localparam int SLOT_W    = 4;
  localparam int CFG_W     = 5;
  localparam int CFG_RESET = 16;

endpackage

[hw/rtl/second_chance_page_replacer.sv]
// Second-chance (clock) page replacer. Each item is one page reference and gives one
// result: hit and slot, or the slot filled on a fault and the page evicted, if any.
// One item is worked at a time. The page store is a one-port-read RAM scanned one
// entry per cycle, and the clock sweep moves the hand one frame per cycle.
// A result waits in an output register; the next item is taken while it waits.
// frames_in_use may only be written while no item is in flight.
module second_chance_page_replacer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [scpr_pkg::PAGE_W-1:0]   in_page,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic [scpr_pkg::SLOT_W-1:0]   out_slot,
  output logic                          out_evicted,
  output logic [scpr_pkg::PAGE_W-1:0]   out_evicted_page,
  input  logic                          cfg_wr_en,
  input  logic [scpr_pkg::CFG_W-1:0]    cfg_wr_data
);
  import scpr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SWEEP,
    ST_EVICT,
    ST_DONE
  } state_t;

  state_t               state_r;
  logic [CFG_W-1:0]     cfg_r;
  logic [CNT_W-1:0]     n_r;
  logic [CNT_W-1:0]     n_sel;
  logic [PAGE_BITS-1:0] page_r;
  logic [FRAMES-1:0]    valid_r;
  logic [FRAMES-1:0]    mark_r;
  logic [FRAME_W-1:0]   hand_r;
  logic [FRAME_W-1:0]   hand_inc;
  logic [CNT_W-1:0]     idx_r;
  logic                 cmp_v_r;
  logic [FRAME_W-1:0]   cmp_idx_r;

  // Pending result
  logic                 res_hit_r;
  logic [FRAME_W-1:0]   res_slot_r;
  logic                 res_evicted_r;
  logic [PAGE_BITS-1:0] res_evp_r;

  // Output register
  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic                 out_evicted_r;
  logic [PAGE_W-1:0]    out_evp_r;

  logic                 ram_we;
  logic [FRAME_W-1:0]   ram_waddr;
  logic                 ram_re;
  logic [FRAME_W-1:0]   ram_raddr;
  logic [PAGE_BITS-1:0] ram_rdata;

  logic                 fill_found;
  logic [FRAME_W-1:0]   fill_idx;
  logic                 search_hit;
  logic                 search_end;
  logic                 out_free;

  // Clamp the frame count to 1..FRAMES
  always_comb begin
    if (cfg_r == '0) begin
      n_sel = CNT_W'(1);
    end else if (int'(cfg_r) > FRAMES) begin
      n_sel = CNT_W'(FRAMES);
    end else begin
      n_sel = CNT_W'(cfg_r);
    end
  end

  // Lowest empty frame in use
  always_comb begin
    fill_found = 1'b0;
    fill_idx   = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < n_r) && !valid_r[i]) begin
        fill_found = 1'b1;
        fill_idx   = FRAME_W'(i);
      end
    end
  end

  // Compare the entry read last cycle
  assign search_hit = cmp_v_r && valid_r[cmp_idx_r] && (ram_rdata == page_r);
  assign search_end = cmp_v_r && (CNT_W'(cmp_idx_r) == n_r - CNT_W'(1));

  // Hand step with wrap at the frame count
  assign hand_inc = (CNT_W'(hand_r) + CNT_W'(1) == n_r) ? '0 : hand_r + FRAME_W'(1);

  // Page store access
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = hand_r;
    ram_we    = 1'b0;
    ram_waddr = fill_idx;
    if (state_r == ST_SEARCH) begin
      ram_re    = idx_r < n_r;
      ram_raddr = idx_r[FRAME_W-1:0];
      ram_we    = !search_hit && search_end && fill_found;
    end else if (state_r == ST_SWEEP) begin
      ram_re    = mark_r[hand_r];
    end else if (state_r == ST_EVICT) begin
      ram_we    = 1'b1;
      ram_waddr = hand_r;
    end
  end

  scpr_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (FRAMES)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (page_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  // Sequencer, frame flags and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_r       <= CFG_W'(CFG_RESET);
      valid_r     <= '0;
      mark_r      <= '0;
      hand_r      <= '0;
      out_valid_r <= 1'b0;
      cmp_v_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      // Drop the result once taken, unless a new one loads in its place
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            page_r  <= in_page[PAGE_BITS-1:0];
            n_r     <= n_sel;
            idx_r   <= '0;
            cmp_v_r <= 1'b0;
            state_r <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          cmp_v_r   <= idx_r < n_r;
          cmp_idx_r <= idx_r[FRAME_W-1:0];
          idx_r     <= idx_r + CNT_W'(1);
          if (search_hit) begin
            mark_r[cmp_idx_r] <= 1'b0;
            res_hit_r         <= 1'b1;
            res_slot_r        <= cmp_idx_r;
            res_evicted_r     <= 1'b0;
            res_evp_r         <= '0;
            state_r           <= ST_DONE;
          end else if (search_end) begin
            if (fill_found) begin
              valid_r[fill_idx] <= 1'b1;
              mark_r[fill_idx]  <= 1'b0;
              res_hit_r         <= 1'b0;
              res_slot_r        <= fill_idx;
              res_evicted_r     <= 1'b0;
              res_evp_r         <= '0;
              state_r           <= ST_DONE;
            end else begin
              // Restart the hand if the frame count shrank under it
              if (CNT_W'(hand_r) >= n_r) begin
                hand_r <= '0;
              end
              state_r <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          if (mark_r[hand_r]) begin
            state_r <= ST_EVICT;
          end else begin
            mark_r[hand_r] <= 1'b1;
            hand_r         <= hand_inc;
          end
        end
        ST_EVICT: begin
          valid_r[hand_r] <= 1'b1;
          mark_r[hand_r]  <= 1'b0;
          res_hit_r       <= 1'b0;
          res_slot_r      <= hand_r;
          res_evicted_r   <= 1'b1;
          res_evp_r       <= ram_rdata;
          hand_r          <= hand_inc;
          state_r         <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_hit_r     <= res_hit_r;
            out_slot_r    <= SLOT_W'(res_slot_r);
            out_evicted_r <= res_evicted_r;
            out_evp_r     <= PAGE_W'(res_evp_r);
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_slot         = out_slot_r;
  assign out_evicted      = out_evicted_r;
  assign out_evicted_page = out_evp_r;

endmodule

[hw/rtl/scpr_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module scpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/scpr_checker.sv]
// Port-level checks for the second-chance page replacer, bound to its top level.
// Depends on scpr_pkg and second_chance_page_replacer_defines.svh.
`include "second_chance_page_replacer_defines.svh"

module scpr_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [scpr_pkg::PAGE_W-1:0]   in_page,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_hit,
  input  logic [scpr_pkg::SLOT_W-1:0]   out_slot,
  input  logic                          out_evicted,
  input  logic [scpr_pkg::PAGE_W-1:0]   out_evicted_page,
  input  logic                          cfg_wr_en,
  input  logic [scpr_pkg::CFG_W-1:0]    cfg_wr_data
);
  import scpr_pkg::*;

  // Hold a stalled result
  `SCPR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_slot) && $stable(out_evicted_page) && $stable(out_hit) && $stable(out_evicted))

  // A hit never evicts
  `SCPR_ASSERT_SAME(a_hit_no_evict, out_valid && out_hit, !out_evicted)

  // No eviction means a zero evicted page
  `SCPR_ASSERT_SAME(a_evp_zero, out_valid && !out_evicted, out_evicted_page == '0)

  // An accepted item keeps the block busy next cycle
  `SCPR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

bind second_chance_page_replacer scpr_checker u_scpr_checker (.*);

[tb/sv/second_chance_page_replacer_checker.sv]
// Checker for the second-chance page replacer: watches the input, result and
// configuration ports, predicts each result and compares it field by field.
// Depends on scpr_pkg for the field widths and the frame count.
module second_chance_page_replacer_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [scpr_pkg::PAGE_W-1:0]   in_page,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_hit,
  input  logic [scpr_pkg::SLOT_W-1:0]   out_slot,
  input  logic                          out_evicted,
  input  logic [scpr_pkg::PAGE_W-1:0]   out_evicted_page,
  input  logic                          cfg_wr_en,
  input  logic [scpr_pkg::CFG_W-1:0]    cfg_wr_data,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import scpr_pkg::*;

  localparam int MAX_LINES = 60;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [PAGE_W-1:0] evicted_page;
  } page_outcome_t;

  // Shadow copy of the frame table
  logic [PAGE_W-1:0] frame_page [FRAMES];
  bit                frame_valid [FRAMES];
  bit                frame_marked [FRAMES];
  int                hand;
  logic [CFG_W-1:0]  frames_cfg;

  page_outcome_t outcome_q[$];

  // Print one line per mismatch, up to a cap, and count every one
  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (fail_count < MAX_LINES)
      $display("%0t ns: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    fail_count++;
  endtask

  // Look up one page reference, update the shadow table, return the outcome
  function automatic page_outcome_t resolve_reference(input logic [PAGE_W-1:0] pg);
    page_outcome_t r;
    int n;
    int steps;
    r = '0;
    if (frames_cfg == 0)
      n = 1;
    else if (frames_cfg > FRAMES)
      n = FRAMES;
    else
      n = int'(frames_cfg);

    // search frames in use for a resident copy
    for (int i = 0; i < n; i++) begin
      if (frame_valid[i] && frame_page[i] == pg) begin
        frame_marked[i] = 1'b0;
        r.hit = 1'b1;
        r.slot = SLOT_W'(i);
        return r;
      end
    end

    // fill the lowest empty frame
    for (int i = 0; i < n; i++) begin
      if (!frame_valid[i]) begin
        frame_page[i] = pg;
        frame_valid[i] = 1'b1;
        frame_marked[i] = 1'b0;
        r.slot = SLOT_W'(i);
        return r;
      end
    end

    // sweep: mark unmarked frames until a marked one is found
    if (hand >= n)
      hand = 0;
    for (steps = 0; steps <= n && !frame_marked[hand]; steps++) begin
      frame_marked[hand] = 1'b1;
      hand = (hand + 1) % n;
    end
    r.slot = SLOT_W'(hand);
    r.evicted = 1'b1;
    r.evicted_page = frame_page[hand];
    frame_page[hand] = pg;
    frame_valid[hand] = 1'b1;
    frame_marked[hand] = 1'b0;
    hand = (hand + 1) % n;
    return r;
  endfunction

  // Track config, predict on accepted items, compare on accepted results
  always @(posedge clk) begin
    page_outcome_t want;
    if (!rst_n) begin
      for (int i = 0; i < FRAMES; i++) begin
        frame_page[i] = '0;
        frame_valid[i] = 1'b0;
        frame_marked[i] = 1'b0;
      end
      hand = 0;
      frames_cfg = CFG_W'(CFG_RESET);
      outcome_q.delete();
    end else begin
      if (cfg_wr_en)
        frames_cfg = cfg_wr_data;
      if (in_valid && !in_stall)
        outcome_q.push_back(resolve_reference(in_page));
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result with no item pending", 32'h0, 32'({out_hit, out_slot}));
        end else begin
          want = outcome_q.pop_front();
          if (out_hit !== want.hit)
            report_mismatch("hit", 32'(want.hit), 32'(out_hit));
          if (out_slot !== want.slot)
            report_mismatch("slot", 32'(want.slot), 32'(out_slot));
          if (out_evicted !== want.evicted)
            report_mismatch("evicted", 32'(want.evicted), 32'(out_evicted));
          if (out_evicted_page !== want.evicted_page)
            report_mismatch("evicted_page", 32'(want.evicted_page),
                            32'(out_evicted_page));
        end
      end
    end
    pending = outcome_q.size();
  end

endmodule

[tb/sv/second_chance_page_replacer_tb.sv]
// Top of the page replacer testbench: clock, reset, page references, result
// back-pressure and frame-count writes, plus the final verdict.
// Depends on scpr_pkg, the replacer RTL and second_chance_page_replacer_checker.
module second_chance_page_replacer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scpr_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [PAGE_W-1:0] in_page = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_hit;
  logic [SLOT_W-1:0] out_slot;
  logic              out_evicted;
  logic [PAGE_W-1:0] out_evicted_page;
  logic              cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]  cfg_wr_data = '0;

  int fail_count;
  int pending;
  bit calm = 1'b0;

  second_chance_page_replacer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_page          (in_page),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_slot         (out_slot),
    .out_evicted      (out_evicted),
    .out_evicted_page (out_evicted_page),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  second_chance_page_replacer_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_page          (in_page),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_slot         (out_slot),
    .out_evicted      (out_evicted),
    .out_evicted_page (out_evicted_page),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // 10 ns clock
  always #5 clk = ~clk;

  // Stall the result channel at random, except in the calm stretch
  always @(negedge clk) begin
    out_stall = rst_n && !calm && ($urandom_range(99) < 38);
  end

  // Bound the run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Present one page reference, with a random gap first, and hold it until taken
  task automatic send_page(input logic [PAGE_W-1:0] pg);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(99) < 38) begin
      gap = $urandom_range(4, 1);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_page = pg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and hold until every predicted result has been taken
  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the frame count while the block is idle
  task automatic set_frames(input logic [CFG_W-1:0] value);
    drain();
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Random references: mostly a small working set near a base, some anywhere
  task automatic run_phase(input logic [CFG_W-1:0] frames, input int count);
    logic [PAGE_W-1:0] base;
    int eff;
    eff = (frames == 0) ? 1 : ((frames > FRAMES) ? FRAMES : int'(frames));
    base = PAGE_W'($urandom);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 70)
        send_page(base ^ PAGE_W'($urandom_range(eff + 2)));
      else
        send_page(PAGE_W'($urandom));
    end
  endtask

  initial begin
    logic [CFG_W-1:0] frame_plan [12];

    // Hold reset, then release it
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: fill every frame, hit the extremes, then force sweeps
    send_page(20'h00000);
    send_page(20'hFFFFF);
    for (int k = 1; k <= 14; k++)
      send_page(PAGE_W'(k * 20'h1111));
    send_page(20'h00000);
    send_page(20'hFFFFF);
    send_page(20'hABCDE);
    send_page(20'h00000);
    send_page(20'h2222);
    send_page(20'h54321);

    // Frame counts: shrink with the hand beyond range, regrow, extremes, out of range
    frame_plan = '{5'd16, 5'd3, 5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2,
                   5'd9, 5'd16, 5'd0, 5'd0};
    frame_plan[10] = CFG_W'($urandom_range(16, 1));
    frame_plan[11] = CFG_W'($urandom_range(31));

    for (int p = 0; p < 12; p++) begin
      if (p > 0)
        set_frames(frame_plan[p]);
      calm = (p == 2);
      run_phase(frame_plan[p], 34);
      // pause mid-phase until all results are back, then carry on
      if (p == 5)
        drain();
      run_phase(frame_plan[p], 34);
    end
    calm = 1'b0;

    // Wait out the last results and a little longer
    drain();
    repeat (50) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
